[rtl/hois_pkg.sv]
// ----------------------------------------------------------------------------
// Half-open interval set package
// Shared state, operation and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hois_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_REMOVE = 2'd1,
		FN_QUERY  = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

endpackage

[rtl/hois_store.sv]
// ----------------------------------------------------------------------------
// Interval store
// Two banks of interval entries in one memory, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hois_store #(
	parameter int AW = 6,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW:0]   wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW:0]   rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [2**(AW+1)];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/half_open_interval_set.sv]
// ----------------------------------------------------------------------------
// Half-open interval set
// Sorted table of disjoint intervals with add, remove and query requests.
// ----------------------------------------------------------------------------
// Add, remove and query requests scan every stored interval and then pass a
// finish state that raises done; splitting an interval or placing a merged
// interval ahead of later entries stalls the scan. Empty-range and unused
// requests answer in the cycle right after they are taken.
// Throughput: one request at a time; the scan reads one memory entry a cycle
// except while stalled, and busy drops in the cycle that carries done.
// The receiver cannot stall: done is high for exactly one cycle per request.
// Reset empties the table at once; memory contents need no clearing.
`timescale 1ns / 1ps

module half_open_interval_set import hois_pkg::*; #(
	parameter int MAX_INTERVALS = 64,
	parameter int COORD_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	output logic        done,
	output logic        covered,
	output logic [1:0]  status
);

	localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int CB = COORD_BITS;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_INTERVALS);

	// The table lives in one of two banks. An add or remove request streams the
	// active bank into the other one, entry by entry, and the banks swap only when
	// the request succeeds, so a dropped request leaves the table untouched.
	state_t        state_q, state_d;
	logic          bank_q;
	logic [CW-1:0] cnt_q, rd_q, wr_q;
	logic          dv_q, ph_q, mdone_q, full_q, cov_q;
	func_t         func_q;
	logic [CB-1:0] lo_q, hi_q, ns_q, ne_q;
	logic          done_q, covered_q;
	logic [1:0]    status_q;

	logic [CB-1:0] lo_in, hi_in;
	logic          req_take, req_quick;

	logic [2*CB-1:0] rdata;
	logic [CB-1:0]   rs, re;

	logic          issue, stall, wreq, qhit;
	logic [CB-1:0] ws, we;
	logic          wr_fit, fin_wreq, fin_full;
	logic [CW-1:0] fin_cnt;

	assign lo_in     = CB'(range_low);
	assign hi_in     = CB'(range_high);
	assign req_take  = start && !busy;
	assign req_quick = (lo_in >= hi_in) || (func_t'(func) == FN_NONE);

	assign rs = rdata[2*CB-1:CB];
	assign re = rdata[CB-1:0];

	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign covered = covered_q;
	assign status  = status_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_take && !req_quick) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!dv_q && (rd_q == cnt_q)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Per-entry decisions for the entry held in the read register.
	always_comb begin
		stall = 1'b0;
		wreq  = 1'b0;
		qhit  = 1'b0;
		ws    = rs;
		we    = re;
		if ((state_q == ST_SCAN) && dv_q) begin
			case (func_q)
				FN_ADD: begin
					if (re < lo_q) begin
						wreq = 1'b1;
					end else if (rs <= hi_q) begin
						wreq = 1'b0;
					end else if (!mdone_q) begin
						// First entry past the merged span: place the span first.
						wreq  = 1'b1;
						ws    = ns_q;
						we    = ne_q;
						stall = 1'b1;
					end else begin
						wreq = 1'b1;
					end
				end
				FN_REMOVE: begin
					if ((re <= lo_q) || (rs >= hi_q)) begin
						wreq = 1'b1;
					end else if ((rs < lo_q) && (re > hi_q)) begin
						// Split: the lower piece now, the upper piece next cycle.
						wreq = 1'b1;
						if (!ph_q) begin
							we    = lo_q;
							stall = 1'b1;
						end else begin
							ws = hi_q;
						end
					end else if (rs < lo_q) begin
						wreq = 1'b1;
						we   = lo_q;
					end else if (re > hi_q) begin
						wreq = 1'b1;
						ws   = hi_q;
					end
				end
				FN_QUERY: begin
					qhit = (rs <= lo_q) && (re >= hi_q);
				end
				default: begin
					wreq = 1'b0;
				end
			endcase
		end
		if (state_q == ST_FIN) begin
			wreq = fin_wreq;
			ws   = ns_q;
			we   = ne_q;
		end
	end

	assign issue    = (state_q == ST_SCAN) && !stall && (rd_q < cnt_q);
	assign wr_fit   = (wr_q < MAX_C);
	assign fin_wreq = (func_q == FN_ADD) && !mdone_q;
	assign fin_full = full_q || (fin_wreq && !wr_fit);
	assign fin_cnt  = fin_wreq ? (wr_q + CW'(1)) : wr_q;

	hois_store #(
		.AW (AW),
		.DW (2*CB)
	) u_store (
		.clk     (clk),
		.wr_en   (wreq && wr_fit),
		.wr_addr ({~bank_q, wr_q[AW-1:0]}),
		.wr_data ({ws, we}),
		.rd_en   (issue),
		.rd_addr ({bank_q, rd_q[AW-1:0]}),
		.rd_data (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bank_q    <= 1'b0;
			cnt_q     <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			dv_q      <= 1'b0;
			ph_q      <= 1'b0;
			mdone_q   <= 1'b0;
			full_q    <= 1'b0;
			cov_q     <= 1'b0;
			func_q    <= FN_ADD;
			done_q    <= 1'b0;
			covered_q <= 1'b0;
			status_q  <= STAT_OK;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						if (req_quick) begin
							done_q    <= 1'b1;
							covered_q <= 1'b0;
							status_q  <= (lo_in >= hi_in) ? STAT_EMPTY : STAT_OK;
						end else begin
							func_q  <= func_t'(func);
							rd_q    <= '0;
							wr_q    <= '0;
							dv_q    <= 1'b0;
							ph_q    <= 1'b0;
							mdone_q <= 1'b0;
							full_q  <= 1'b0;
							cov_q   <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_q <= rd_q + CW'(1);
					end
					dv_q <= stall || issue;
					ph_q <= stall;
					if (stall && (func_q == FN_ADD)) begin
						mdone_q <= 1'b1;
					end
					if (qhit) begin
						cov_q <= 1'b1;
					end
					if (wreq) begin
						if (wr_fit) begin
							wr_q <= wr_q + CW'(1);
						end else begin
							full_q <= 1'b1;
						end
					end
				end
				ST_FIN: begin
					done_q    <= 1'b1;
					covered_q <= (func_q == FN_QUERY) && cov_q;
					status_q  <= fin_full ? STAT_FULL : STAT_OK;
					if (!fin_full && (func_q != FN_QUERY)) begin
						bank_q <= ~bank_q;
						cnt_q  <= fin_cnt;
					end
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// Request and merged span registers carry no reset.
	always_ff @(posedge clk) begin
		if (req_take && !req_quick) begin
			lo_q <= lo_in;
			hi_q <= hi_in;
			ns_q <= lo_in;
			ne_q <= hi_in;
		end else if ((state_q == ST_SCAN) && dv_q && (func_q == FN_ADD) &&
			     (re >= lo_q) && (rs <= hi_q)) begin
			if (rs < ns_q) begin
				ns_q <= rs;
			end
			if (re > ne_q) begin
				ne_q <= re;
			end
		end
	end

endmodule

[test/interval_set_checker.sv]
// ----------------------------------------------------------------------------
// Interval set checker
// Watches the request and result channels, keeps its own interval table and
// compares every result with the predicted covered flag and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interval_set_checker import hois_pkg::*; #(
	parameter int MAX_INTERVALS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  func,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	input  logic        done,
	input  logic        covered,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic       covered;
		logic [1:0] status;
	} answer_t;

	logic [31:0] iv_lo [MAX_INTERVALS];
	logic [31:0] iv_hi [MAX_INTERVALS];
	int          iv_num;
	answer_t     answers_due [$];

	// Replace table entries [first, last) by up to two new pieces.
	function automatic void replace_span(input int first, input int last, input int npc,
			input logic [31:0] s0, input logic [31:0] e0,
			input logic [31:0] s1, input logic [31:0] e1);
		logic [31:0] ts [$];
		logic [31:0] te [$];
		for (int k = 0; k < first; k++) begin
			ts.push_back(iv_lo[k]);
			te.push_back(iv_hi[k]);
		end
		if (npc > 0) begin
			ts.push_back(s0);
			te.push_back(e0);
		end
		if (npc > 1) begin
			ts.push_back(s1);
			te.push_back(e1);
		end
		for (int k = last; k < iv_num; k++) begin
			ts.push_back(iv_lo[k]);
			te.push_back(iv_hi[k]);
		end
		iv_num = ts.size();
		for (int k = 0; k < iv_num; k++) begin
			iv_lo[k] = ts[k];
			iv_hi[k] = te[k];
		end
	endfunction

	function automatic answer_t apply_request(input logic [1:0] fn,
			input logic [31:0] lo, input logic [31:0] hi);
		answer_t a;
		int i, j, npc;
		logic [31:0] s0, e0, s1, e1;
		a = '0;
		a.status = STAT_OK;
		i = 0;
		npc = 0;
		if (lo >= hi) begin
			a.status = STAT_EMPTY;
		end else if (fn == FN_ADD) begin
			while (i < iv_num && iv_hi[i] < lo) i++;
			j = i;
			while (j < iv_num && iv_lo[j] <= hi) j++;
			if (i == j && iv_num >= MAX_INTERVALS) begin
				a.status = STAT_FULL;
			end else begin
				s0 = lo;
				e0 = hi;
				if (j > i) begin
					if (iv_lo[i] < s0) s0 = iv_lo[i];
					if (iv_hi[j-1] > e0) e0 = iv_hi[j-1];
				end
				replace_span(i, j, 1, s0, e0, '0, '0);
			end
		end else if (fn == FN_REMOVE) begin
			while (i < iv_num && iv_hi[i] <= lo) i++;
			j = i;
			while (j < iv_num && iv_lo[j] < hi) j++;
			if (j > i) begin
				// Keep the parts that stick out on either side.
				if (iv_lo[i] < lo) begin
					s0 = iv_lo[i];
					e0 = lo;
					npc++;
				end
				if (iv_hi[j-1] > hi) begin
					if (npc == 0) begin
						s0 = hi;
						e0 = iv_hi[j-1];
					end else begin
						s1 = hi;
						e1 = iv_hi[j-1];
					end
					npc++;
				end
				if (iv_num - (j - i) + npc > MAX_INTERVALS) a.status = STAT_FULL;
				else replace_span(i, j, npc, s0, e0, s1, e1);
			end
		end else if (fn == FN_QUERY) begin
			for (int k = 0; k < iv_num; k++)
				if (iv_lo[k] <= lo && iv_hi[k] >= hi) a.covered = 1'b1;
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t exp_a;
		int      errs;
		errs = 0;
		if (!arst_n) begin
			iv_num = 0;
			fail_count <= 0;
			pending <= 0;
			answers_due.delete();
		end else begin
			if (done) begin
				if (answers_due.size() == 0) begin
					$error("result with no request waiting");
					errs++;
				end else begin
					exp_a = answers_due.pop_front();
					if (covered !== exp_a.covered) begin
						$error("covered: expected %0d, actual %0d", exp_a.covered, covered);
						errs++;
					end
					if (status !== exp_a.status) begin
						$error("status: expected %0d, actual %0d", exp_a.status, status);
						errs++;
					end
				end
			end
			if (start && !busy)
				answers_due.push_back(apply_request(func, range_low, range_high));
			fail_count <= fail_count + errs;
			pending <= answers_due.size();
		end
	end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Interval set testbench
// Drives add, remove, query and no-operation requests with random gaps into the
// interval set and lets the checker judge every result against its own table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import hois_pkg::*; ();

	localparam int MAX_IV = 64;
	// Cycle limit for the watchdog, with a large margin over the slowest request.
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [31:0] range_low;
	logic [31:0] range_high;
	logic        done;
	logic        covered;
	logic [1:0]  status;
	int          fail_count;
	int          pending;
	int          cycles;
	int          idle_pct;

	half_open_interval_set #(.MAX_INTERVALS(MAX_IV), .COORD_BITS(32)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.range_low(range_low), .range_high(range_high), .done(done),
		.covered(covered), .status(status)
	);

	interval_set_checker #(.MAX_INTERVALS(MAX_IV)) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.range_low(range_low), .range_high(range_high), .done(done),
		.covered(covered), .status(status), .fail_count(fail_count),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Present one request and hold it until the block takes it. Gaps are
	// inserted ahead of a request so that they land in every phase of the
	// scan, not only right after a result. Start stays high between two
	// requests sent back to back.
	task automatic send_request(input logic [1:0] fn, input logic [31:0] lo,
			input logic [31:0] hi);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		start <= 1'b1;
		func <= fn;
		range_low <= lo;
		range_high <= hi;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Random request. Most coordinates sit in a narrow window so that adds,
	// removes and queries hit stored intervals; a few use the full range.
	task automatic random_request();
		logic [1:0]  fn;
		logic [31:0] lo, hi;
		int          pick;
		pick = $urandom_range(99);
		fn = (pick < 45) ? FN_ADD : (pick < 75) ? FN_REMOVE :
			(pick < 97) ? FN_QUERY : FN_NONE;
		if ($urandom_range(9) == 0) begin
			lo = $urandom;
			hi = $urandom;
		end else begin
			lo = $urandom_range(2000);
			hi = lo + $urandom_range(40);
			if ($urandom_range(19) == 0) hi = lo - $urandom_range(3);
		end
		send_request(fn, lo, hi);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_ADD;
		range_low = '0;
		range_high = '0;
		idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: field extremes, each operation, empty ranges,
		// merging of touching ranges, truncation and a split.
		send_request(FN_QUERY, 32'd0, 32'd1);
		send_request(FN_ADD, 32'd0, 32'hFFFF_FFFF);
		send_request(FN_QUERY, 32'd0, 32'hFFFF_FFFF);
		send_request(FN_REMOVE, 32'h5555_5555, 32'hAAAA_AAAA);
		send_request(FN_QUERY, 32'd0, 32'h5555_5555);
		send_request(FN_QUERY, 32'd10, 32'hAAAA_AAAB);
		send_request(FN_REMOVE, 32'd0, 32'hFFFF_FFFF);
		send_request(FN_ADD, 32'd7, 32'd7);
		send_request(FN_ADD, 32'hFFFF_FFFF, 32'd0);
		send_request(FN_REMOVE, 32'd9, 32'd3);
		send_request(FN_NONE, 32'd1, 32'd5);
		send_request(FN_ADD, 32'd10, 32'd20);
		send_request(FN_ADD, 32'd20, 32'd30);
		send_request(FN_ADD, 32'd40, 32'd50);
		send_request(FN_ADD, 32'd25, 32'd45);
		send_request(FN_QUERY, 32'd10, 32'd50);
		send_request(FN_REMOVE, 32'd15, 32'd18);
		send_request(FN_REMOVE, 32'd5, 32'd12);
		send_request(FN_REMOVE, 32'd45, 32'd60);
		send_request(FN_QUERY, 32'd18, 32'd45);
		send_request(FN_REMOVE, 32'd0, 32'd100);

		// Fill the table past its size with separated ranges, then force a
		// split on the full table; both must be dropped as table-full.
		for (int k = 0; k < MAX_IV + 2; k++)
			send_request(FN_ADD, 32'd1000 * k, 32'd1000 * k + 32'd10);
		send_request(FN_REMOVE, 32'd3, 32'd5);
		send_request(FN_QUERY, 32'd3, 32'd5);
		send_request(FN_REMOVE, 32'd0, 32'hFFFF_FFFF);

		// Random part in three idle phases.
		idle_pct = 27;
		repeat (250) random_request();
		idle_pct = 45;
		repeat (250) random_request();
		idle_pct = 0;
		repeat (250) random_request();
		start <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
